>>> src/pidaw_pkg.sv
package pidaw_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FIELD_W = 32;
  localparam int GAIN_W = 31;
  localparam int ALPHA_W = 17;
  localparam int DT_W = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int GDT_W = GAIN_W + DT_W;
  localparam int DIV_N = FIELD_W + 1 + DT_W;
  localparam int SH_G = 16;
  localparam int SH_I = 40;

  localparam logic [DT_W-1:0] DT_MIN = DT_W'(16);
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEG_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_LIMIT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_DFILT_ALPHA = 3'd5;

  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ERR,
    ST_DIV,
    ST_RATE,
    ST_FILT,
    ST_FMUL,
    ST_FUPD,
    ST_PLOAD,
    ST_PMUL,
    ST_DLOAD,
    ST_DMUL,
    ST_SUM,
    ST_GMUL,
    ST_ILOAD,
    ST_IMUL,
    ST_IUPD,
    ST_OUT
  } state_t;

endpackage

>>> src/pid_antiwindup_dfilter_unit.sv
// PID controller in signed Q16.16 with derivative on measurement, a first-order
// low-pass filter on the derivative, a clamped integrator and conditional
// anti-windup. A clear transaction (cmd = 1) gives no result. A control step
// runs through one shift-add multiplier that retires one multiplier bit per
// cycle and a restoring divider that retires one quotient bit per cycle. A step
// uses up to five products and one division, and fewer when the derivative or
// the integrator update is skipped. A finished result waits in the output
// register while the next transaction is taken.
module pid_antiwindup_dfilter_unit #(
  parameter int VALUE_WIDTH = pidaw_pkg::VALUE_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [pidaw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pidaw_pkg::FIELD_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic cmd,
  input  logic signed [pidaw_pkg::FIELD_W-1:0] setpoint,
  input  logic signed [pidaw_pkg::FIELD_W-1:0] measured,
  input  logic [pidaw_pkg::DT_W-1:0] time_step,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [pidaw_pkg::FIELD_W-1:0] drive,
  output logic integ_held
);
  import pidaw_pkg::*;

  localparam int W = VALUE_WIDTH;
  localparam int MA = (W + 1 > GDT_W) ? W + 1 : GDT_W;
  localparam int MB = (W > GAIN_W) ? W : GAIN_W;
  localparam int PW = MA + MB;
  localparam int XW = PW + 2;
  localparam int CNTW = $clog2((MB > DIV_N) ? MB : DIV_N);
  localparam logic signed [XW-1:0] VMAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [XW-1:0] VMIN_X = ~VMAX_X;

  function automatic logic signed [W-1:0] satw(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] r;
    r = x;
    if (x > VMAX_X) r = VMAX_X;
    if (x < VMIN_X) r = VMIN_X;
    return r[W-1:0];
  endfunction

  function automatic logic signed [XW-1:0] floor_shift(input logic [PW-1:0] p,
                                                     input logic neg,
                                                     input logic sh40);
    logic [PW-1:0] q;
    logic rnz;
    logic signed [XW-1:0] m;
    q = sh40 ? (p >> SH_I) : (p >> SH_G);
    rnz = sh40 ? |p[SH_I-1:0] : |p[SH_G-1:0];
    m = signed'({2'b00, q}) + signed'({{(XW-1){1'b0}}, rnz & neg});
    return neg ? -m : m;
  endfunction

  function automatic logic signed [XW-1:0] clamp_sym(input logic signed [XW-1:0] x,
                                                   input logic [GAIN_W-1:0] lim);
    logic signed [XW-1:0] l;
    logic signed [XW-1:0] r;
    l = signed'({{(XW-GAIN_W){1'b0}}, lim});
    r = x;
    if (x > l) r = l;
    if (x < -l) r = -l;
    return r;
  endfunction

  // Configuration registers.
  logic [GAIN_W-1:0] gain_p, gain_i, gain_d, integ_limit, drive_limit;
  logic [ALPHA_W-1:0] dfilt_alpha;

  // Controller state.
  logic signed [W-1:0] integ_acc;
  logic signed [FIELD_W-1:0] last_meas;
  logic have_last;
  logic signed [W-1:0] dfilt_value;
  logic dfilt_primed;

  // Per-step working registers.
  state_t state, state_next;
  logic signed [FIELD_W-1:0] sp_r, meas_r;
  logic [DT_W-1:0] dt_r;
  logic signed [W-1:0] err, xval, dval, tp, pd;
  logic held;
  logic rate_used;

  // Shift-add multiplier and restoring divider.
  logic [PW-1:0] mul_a, mul_acc;
  logic [MB-1:0] mul_b;
  logic mul_neg, mul_sh40;
  logic [DIV_N-1:0] div_q;
  logic [DT_W:0] div_r;
  logic div_neg;
  logic [CNTW-1:0] cnt;

  logic mul_done, div_done, deriv_on;
  logic signed [XW-1:0] err_x, mul_res, ynew_x, fdiff_x, err_mag, d_mag;
  logic signed [XW-1:0] rate_x, sum_pd_x, total_x, inc_acc_x, out_x;
  logic signed [W-1:0] ynew, td, pd_new;
  logic signed [FIELD_W:0] mdiff;
  logic [FIELD_W:0] mdiff_mag;
  logic [DT_W+1:0] div_trial;
  logic [ALPHA_W-1:0] alpha_c;
  logic sat_hi, sat_lo, allow;

  assign mul_done = (cnt == CNTW'(MB - 1));
  assign div_done = (cnt == CNTW'(DIV_N - 1));
  assign deriv_on = (gain_d != '0) && have_last && (dt_r > DT_MIN);

  always_comb begin
    err_x = XW'(err);
    err_mag = err_x[XW-1] ? -err_x : err_x;
    d_mag = (XW'(dval) < 0) ? -XW'(dval) : XW'(dval);
    mul_res = floor_shift(mul_acc, mul_neg, mul_sh40);
    fdiff_x = XW'(xval) - XW'(dfilt_value);
    ynew = satw(XW'(dfilt_value) + mul_res);
    ynew_x = XW'(ynew);
    mdiff = (FIELD_W+1)'(meas_r) - (FIELD_W+1)'(last_meas);
    mdiff_mag = mdiff[FIELD_W] ? (FIELD_W+1)'(-mdiff) : mdiff;
    div_trial = {1'b0, div_r[DT_W-1:0], div_q[DIV_N-1]} - {2'b00, dt_r};
    rate_x = signed'({{(XW-DIV_N){1'b0}}, div_q});
    if (div_neg) rate_x = -rate_x;
    alpha_c = (dfilt_alpha > ALPHA_ONE) ? ALPHA_ONE : dfilt_alpha;
    td = satw(mul_res);
    pd_new = satw(XW'(tp) + XW'(td));
    sum_pd_x = XW'(satw(XW'(pd_new) + XW'(integ_acc)));
    sat_hi = sum_pd_x > signed'({{(XW-GAIN_W){1'b0}}, drive_limit});
    sat_lo = sum_pd_x < -signed'({{(XW-GAIN_W){1'b0}}, drive_limit});
    allow = (!sat_hi || err < 0) && (!sat_lo || err > 0);
    inc_acc_x = clamp_sym(XW'(satw(XW'(integ_acc) + XW'(satw(mul_res)))), integ_limit);
    total_x = XW'(satw(XW'(pd) + XW'(integ_acc)));
    out_x = clamp_sym(total_x, drive_limit);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = (cmd == CMD_CLEAR) ? ST_IDLE : ST_ERR;
      ST_ERR: begin
        if (gain_d == '0) state_next = ST_PLOAD;
        else if (deriv_on) state_next = ST_DIV;
        else state_next = ST_FILT;
      end
      ST_DIV: if (div_done) state_next = ST_RATE;
      ST_RATE: state_next = ST_FILT;
      ST_FILT: state_next = dfilt_primed ? ST_FMUL : ST_PLOAD;
      ST_FMUL: if (mul_done) state_next = ST_FUPD;
      ST_FUPD: state_next = ST_PLOAD;
      ST_PLOAD: state_next = ST_PMUL;
      ST_PMUL: if (mul_done) state_next = ST_DLOAD;
      ST_DLOAD: state_next = ST_DMUL;
      ST_DMUL: if (mul_done) state_next = ST_SUM;
      ST_SUM: state_next = allow ? ST_GMUL : ST_OUT;
      ST_GMUL: if (mul_done) state_next = ST_ILOAD;
      ST_ILOAD: state_next = ST_IMUL;
      ST_IMUL: if (mul_done) state_next = ST_IUPD;
      ST_IUPD: state_next = ST_OUT;
      ST_OUT: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    cfg_ready = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      gain_p <= '0;
      gain_i <= '0;
      gain_d <= '0;
      integ_limit <= '0;
      drive_limit <= '0;
      dfilt_alpha <= ALPHA_ONE;
      integ_acc <= '0;
      last_meas <= '0;
      have_last <= 1'b0;
      dfilt_value <= '0;
      dfilt_primed <= 1'b0;
      cnt <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          REG_GAIN_P: gain_p <= cfg_data[GAIN_W-1:0];
          REG_GAIN_I: gain_i <= cfg_data[GAIN_W-1:0];
          REG_GAIN_D: gain_d <= cfg_data[GAIN_W-1:0];
          REG_INTEG_LIMIT: integ_limit <= cfg_data[GAIN_W-1:0];
          REG_OUT_LIMIT: drive_limit <= cfg_data[GAIN_W-1:0];
          REG_DFILT_ALPHA: dfilt_alpha <= cfg_data[ALPHA_W-1:0];
          default: ;
        endcase
      end
      if (state == ST_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (state inside {ST_FMUL, ST_PMUL, ST_DMUL, ST_GMUL, ST_IMUL}) begin
        if (mul_b[0]) mul_acc <= mul_acc + mul_a;
        mul_a <= mul_a << 1;
        mul_b <= mul_b >> 1;
        cnt <= cnt + 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (cmd == CMD_CLEAR) begin
              integ_acc <= '0;
              have_last <= 1'b0;
              dfilt_primed <= 1'b0;
            end else begin
              sp_r <= setpoint;
              meas_r <= measured;
              dt_r <= time_step;
            end
          end
        end
        ST_ERR: begin
          err <= satw(XW'(sp_r) - XW'(meas_r));
          last_meas <= meas_r;
          have_last <= 1'b1;
          rate_used <= deriv_on;
          div_q <= {mdiff_mag, {DT_W{1'b0}}};
          div_r <= '0;
          div_neg <= mdiff[FIELD_W];
          xval <= '0;
          dval <= '0;
          cnt <= '0;
        end
        ST_DIV: begin
          if (!div_trial[DT_W+1]) begin
            div_r <= div_trial[DT_W:0];
            div_q <= {div_q[DIV_N-2:0], 1'b1};
          end else begin
            div_r <= {div_r[DT_W-1:0], div_q[DIV_N-1]};
            div_q <= {div_q[DIV_N-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
        end
        ST_RATE: xval <= satw(rate_x);
        ST_FILT: begin
          if (!dfilt_primed) begin
            dfilt_value <= xval;
            dfilt_primed <= 1'b1;
            dval <= satw(-XW'(xval));
          end
          mul_a <= fdiff_x[XW-1] ? PW'(-fdiff_x) : PW'(fdiff_x);
          mul_b <= MB'(alpha_c);
          mul_acc <= '0;
          mul_neg <= fdiff_x[XW-1];
          mul_sh40 <= 1'b0;
          cnt <= '0;
        end
        ST_FUPD: begin
          dfilt_value <= ynew;
          // A filter fed with zero still settles, but the D term stays zero.
          dval <= rate_used ? satw(-ynew_x) : '0;
        end
        ST_PLOAD: begin
          mul_a <= PW'(err_mag);
          mul_b <= MB'(gain_p);
          mul_acc <= '0;
          mul_neg <= err < 0;
          mul_sh40 <= 1'b0;
          cnt <= '0;
        end
        ST_DLOAD: begin
          tp <= satw(mul_res);
          mul_a <= PW'(d_mag);
          mul_b <= MB'(gain_d);
          mul_acc <= '0;
          mul_neg <= dval < 0;
          mul_sh40 <= 1'b0;
          cnt <= '0;
        end
        ST_SUM: begin
          pd <= pd_new;
          held <= !allow;
          mul_a <= PW'(gain_i);
          mul_b <= MB'(dt_r);
          mul_acc <= '0;
          cnt <= '0;
        end
        ST_ILOAD: begin
          // The exact gain_i * time_step product becomes the next multiplicand.
          mul_a <= {{(PW-GDT_W){1'b0}}, mul_acc[GDT_W-1:0]};
          mul_b <= MB'(err_mag);
          mul_acc <= '0;
          mul_neg <= err < 0;
          mul_sh40 <= 1'b1;
          cnt <= '0;
        end
        ST_IUPD: integ_acc <= inc_acc_x[W-1:0];
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            drive <= out_x[FIELD_W-1:0];
            integ_held <= held;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
